@@ sv/mmf_pkg.sv @@
// shared types and constants for the fixed-point matrix multiply core
// no dependencies
package mmf_pkg;

    localparam int DEF_MAX_N = 16;
    localparam int SIZE_W    = 5;
    localparam int FIELD_W   = 4;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 48;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_ROW     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_EMIT
    } mmf_state_t;

    // one element of the A row travelling along the cells
    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        logic signed [ELEM_W-1:0] a;
    } mmf_lane_t;

    // B element write, broadcast to every cell
    typedef struct packed {
        logic               we;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic [ELEM_W-1:0]  data;
    } mmf_bwr_t;

endpackage

@@ sv/mmf_cell.sv @@
// one column cell: holds a column of B, multiplies and accumulates one C element
// depends on mmf_pkg
module mmf_cell #(
    parameter int MAX_N = mmf_pkg::DEF_MAX_N,
    parameter int COL   = 0,
    parameter int IDX_W = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mmf_pkg::mmf_lane_t        lane_in,
    input  logic [IDX_W-1:0]          k_in,
    output mmf_pkg::mmf_lane_t        lane_out,
    output logic [IDX_W-1:0]          k_out,
    input  mmf_pkg::mmf_bwr_t         bwr,
    input  logic                      shift,
    input  logic [mmf_pkg::ACC_W-1:0] acc_in,
    output logic [mmf_pkg::ACC_W-1:0] acc_out,
    output logic                      done
);
    import mmf_pkg::*;

    logic [ELEM_W-1:0]        b_mem [MAX_N];
    logic signed [ELEM_W-1:0] b_rd_reg;
    mmf_lane_t                lane1_reg;
    logic [IDX_W-1:0]         k1_reg;
    logic                     v2_reg;
    logic                     first2_reg;
    logic                     last2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic                     done_reg;
    logic                     b_hit;

    assign b_hit     = bwr.we && (32'(bwr.col) == COL);
    assign prod_next = lane1_reg.a * b_rd_reg;

    always_ff @(posedge clk)
    begin
        if (b_hit)
        begin
            b_mem[IDX_W'(bwr.row)] <= bwr.data;
        end
        b_rd_reg <= $signed(b_mem[k_in]);
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        k1_reg   <= k_in;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (shift)
        begin
            acc_next = acc_in;
        end
        else if (v2_reg)
        begin
            if (first2_reg)
            begin
                acc_next = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
            else
            begin
                acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane1_reg  <= '0;
            v2_reg     <= 1'b0;
            first2_reg <= 1'b0;
            last2_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            lane1_reg  <= lane_in;
            v2_reg     <= lane1_reg.valid;
            first2_reg <= lane1_reg.first;
            last2_reg  <= lane1_reg.last;
            done_reg   <= v2_reg && last2_reg;
        end
    end

    assign lane_out = lane1_reg;
    assign k_out    = k1_reg;
    assign acc_out  = acc_reg;
    assign done     = done_reg;

endmodule

@@ sv/mmf_ctrl.sv @@
// sequencer: decodes input beats, holds the A store, feeds A rows into the
// cell chain and paces the output beats; depends on mmf_pkg
module mmf_ctrl #(
    parameter int MAX_N = mmf_pkg::DEF_MAX_N,
    parameter int IDX_W = 4,
    parameter int NW    = 5,
    parameter int AW    = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,
    input  logic [1:0]                  s_tuser,
    input  logic                        cfg_we,
    input  logic [mmf_pkg::SIZE_W-1:0]  cfg_wdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic                        m_tlast,
    output logic [mmf_pkg::FIELD_W-1:0] out_col,
    input  logic [MAX_N-1:0]            done_vec,
    output mmf_pkg::mmf_lane_t          feed,
    output logic [IDX_W-1:0]            feed_k,
    output mmf_pkg::mmf_bwr_t           bwr,
    output logic                        shift
);
    import mmf_pkg::*;

    mmf_state_t         state_reg;
    mmf_state_t         state_next;
    logic [SIZE_W-1:0]  size_reg;
    logic [FIELD_W-1:0] row_reg;
    logic [NW-1:0]      k_reg;
    logic [NW-1:0]      k_next;
    logic [NW-1:0]      col_reg;
    logic [NW-1:0]      col_next;
    logic               iss_valid_reg;
    logic               iss_first_reg;
    logic               iss_last_reg;
    logic [IDX_W-1:0]   iss_k_reg;
    logic [ELEM_W-1:0]  a_mem [MAX_N*MAX_N];
    logic [ELEM_W-1:0]  a_rd_reg;
    logic [NW-1:0]      n_eff;
    logic [NW-1:0]      n_m1;
    logic               accept;
    logic [FIELD_W-1:0] in_row;
    logic [FIELD_W-1:0] in_col;
    logic [ELEM_W-1:0]  in_value;
    logic               in_range;
    logic               row_ok;
    logic               a_we;
    logic [AW-1:0]      a_waddr;
    logic [AW-1:0]      a_raddr;
    logic               feeding;
    logic               k_end;
    logic               col_end;

    assign in_row   = s_tdata[3:0];
    assign in_col   = s_tdata[7:4];
    assign in_value = s_tdata[23:8];
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(size_reg) > MAX_N)
        begin
            n_eff = NW'(MAX_N);
        end
        else
        begin
            n_eff = NW'(size_reg);
        end
    end

    assign n_m1     = n_eff - NW'(1);
    assign in_range = (32'(in_row) < MAX_N) && (32'(in_col) < MAX_N);
    assign row_ok   = 32'(in_row) < 32'(n_eff);
    assign a_we     = accept && (s_tuser == OP_WRITE_A) && in_range;
    assign a_waddr  = AW'(32'(in_row) * MAX_N + 32'(in_col));
    assign a_raddr  = AW'(32'(row_reg) * MAX_N + 32'(k_reg));
    assign k_end    = (k_reg == n_m1);
    assign col_end  = (col_reg == n_m1);

    always_comb
    begin
        bwr.we   = accept && (s_tuser == OP_WRITE_B) && in_range;
        bwr.row  = in_row;
        bwr.col  = in_col;
        bwr.data = in_value;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == OP_ROW) && row_ok)
                begin
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                if (k_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (done_vec[IDX_W'(n_m1)])
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (m_tready && col_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        feeding  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_FEED:
            begin
                feeding = 1'b1;
            end
            ST_DRAIN:
            begin
                feeding = 1'b0;
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign shift   = m_tvalid && m_tready;
    assign m_tlast = col_end;
    assign out_col = FIELD_W'(col_reg);

    always_comb
    begin
        k_next = k_reg;
        if (accept)
        begin
            k_next = '0;
        end
        else if (feeding)
        begin
            k_next = k_reg + NW'(1);
        end
    end

    always_comb
    begin
        col_next = col_reg;
        if (state_reg == ST_DRAIN)
        begin
            col_next = '0;
        end
        else if (shift)
        begin
            col_next = col_reg + NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[a_waddr] <= in_value;
        end
        if (feeding)
        begin
            a_rd_reg <= a_mem[a_raddr];
        end
        if (accept)
        begin
            row_reg <= in_row;
        end
        iss_k_reg <= IDX_W'(k_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= SIZE_RESET;
            k_reg         <= '0;
            col_reg       <= '0;
            iss_valid_reg <= 1'b0;
            iss_first_reg <= 1'b0;
            iss_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            col_reg       <= col_next;
            iss_valid_reg <= feeding;
            iss_first_reg <= feeding && (k_reg == '0);
            iss_last_reg  <= feeding && k_end;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        feed.valid = iss_valid_reg;
        feed.first = iss_first_reg;
        feed.last  = iss_last_reg;
        feed.a     = $signed(a_rd_reg);
    end

    assign feed_k = iss_k_reg;

endmodule

@@ sv/matrix_multiply_fixed_core.sv @@
// top level of the fixed-point square matrix multiply core
// depends on mmf_pkg, mmf_ctrl and mmf_cell
//
// Square matrix product C = A x B of order n (size register, 1 to MAX_N) on
// signed Q8.8 elements, giving exact signed Q32.16 dot products in 48 bits.
// Load beats write one element of A or B. A row beat streams row r of A,
// one element a cycle from the single-port A store, along a chain of MAX_N
// column cells; cell j keeps column j of B and builds C[r][j]. The finished
// row then shifts out of cell 0, one output beat per column, the last one
// marked by m_tlast. A row beat occupies the core from its acceptance, while
// the A row is fed and until the last used cell has its sum, and through its
// n output beats. One item is worked on at a time; s_tready is low until the
// row has been delivered.
module matrix_multiply_fixed_core #(
    parameter int MAX_N = mmf_pkg::DEF_MAX_N
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,   // row_index, col_index, element_value
    input  logic [1:0]                 s_tuser,   // opcode
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [55:0]                m_tdata,   // out_column, product_value, zero pad
    output logic                       m_tlast,   // last_of_row
    input  logic                       cfg_we,
    input  logic [mmf_pkg::SIZE_W-1:0] cfg_wdata  // size_in_use
);
    import mmf_pkg::*;

    localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int NW    = $clog2(MAX_N + 1);
    localparam int AW    = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1;

    mmf_lane_t          lane [MAX_N+1];
    logic [IDX_W-1:0]   lane_k [MAX_N+1];
    logic [ACC_W-1:0]   acc [MAX_N+1];
    logic [MAX_N-1:0]   done_vec;
    mmf_bwr_t           bwr;
    logic               shift;
    logic [FIELD_W-1:0] out_col;

    mmf_ctrl #(
        .MAX_N (MAX_N),
        .IDX_W (IDX_W),
        .NW    (NW),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .out_col   (out_col),
        .done_vec  (done_vec),
        .feed      (lane[0]),
        .feed_k    (lane_k[0]),
        .bwr       (bwr),
        .shift     (shift)
    );

    assign acc[MAX_N] = '0;

    for (genvar j = 0; j < MAX_N; j++)
    begin : g_cell
        mmf_cell #(
            .MAX_N (MAX_N),
            .COL   (j),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .lane_in  (lane[j]),
            .k_in     (lane_k[j]),
            .lane_out (lane[j+1]),
            .k_out    (lane_k[j+1]),
            .bwr      (bwr),
            .shift    (shift),
            .acc_in   (acc[j+1]),
            .acc_out  (acc[j]),
            .done     (done_vec[j])
        );
    end

    assign m_tdata = {4'b0000, acc[0], out_col};

    // one item at a time: no input beat while a result is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is offered");

    // row ends after its last beat
    a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("result still offered after last beat of row");

    // every row starts at column zero
    a_first_col: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> (m_tdata[3:0] == 4'd0))
        else $error("row did not start at column zero");

endmodule

@@ tb/sv/matrix_multiply_fixed_core_test.sv @@
// testbench for matrix_multiply_fixed_core: loads A and B elements, requests rows of C
// and checks every output beat against a scoreboard that computes the exact dot products
// depends on mmf_pkg and matrix_multiply_fixed_core
`timescale 1ns / 1ps

module matrix_multiply_fixed_core_test;
    import mmf_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 3 * DEF_MAX_N + 12;
    localparam int HOLD_CYCLES   = 400;

    class mm_row_scoreboard;
        typedef struct {
            logic [FIELD_W-1:0]      col;
            logic signed [ACC_W-1:0] value;
            logic                    last;
        } c_elem_t;

        c_elem_t           want_q[$];
        logic [ELEM_W-1:0] a_mem[DEF_MAX_N * DEF_MAX_N];
        logic [ELEM_W-1:0] b_mem[DEF_MAX_N * DEF_MAX_N];
        logic [SIZE_W-1:0] size_reg;
        int                mismatches;
        bit                failed;

        function new();
            size_reg   = SIZE_RESET;
            mismatches = 0;
            failed     = 0;
            foreach (a_mem[i])
            begin
                a_mem[i] = '0;
                b_mem[i] = '0;
            end
        endfunction

        function int order();
            if (size_reg == 0)
                return 1;
            if (size_reg > DEF_MAX_N)
                return DEF_MAX_N;
            return int'(size_reg);
        endfunction

        function void set_size(input logic [SIZE_W-1:0] v);
            size_reg = v;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void note_beat(input logic [1:0] op, input logic [FIELD_W-1:0] row,
                                input logic [FIELD_W-1:0] col, input logic [ELEM_W-1:0] val);
            int                      n;
            int                      j;
            int                      k;
            logic signed [ACC_W-1:0] acc;
            logic signed [PROD_W-1:0] prod;
            c_elem_t                 e;
            n = order();
            case (op)
                OP_WRITE_A: a_mem[{row, col}] = val;
                OP_WRITE_B: b_mem[{row, col}] = val;
                OP_ROW:
                begin
                    if (row < n)
                    begin
                        for (j = 0; j < n; j++)
                        begin
                            acc = '0;
                            for (k = 0; k < n; k++)
                            begin
                                prod = $signed(a_mem[{row, 4'(k)}])
                                     * $signed(b_mem[{4'(k), 4'(j)}]);
                                acc = acc + prod;
                            end
                            e.col   = 4'(j);
                            e.value = acc;
                            e.last  = (j == n - 1);
                            want_q.push_back(e);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(input logic [FIELD_W-1:0] col,
                                   input logic signed [ACC_W-1:0] value, input logic last);
            c_elem_t e;
            if (want_q.size() == 0)
            begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat col=%0d value=%0d last=%0b",
                             $realtime, col, value, last);
                return;
            end
            e = want_q.pop_front();
            if (e.col !== col || e.value !== value || e.last !== last)
            begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: mismatch expected col=%0d value=%0d last=%0b",
                             $realtime, e.col, e.value, e.last);
                    $display("    got col=%0d value=%0d last=%0b", col, value, last);
                end
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata   = '0;
    logic [1:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [55:0]         m_tdata;
    logic                m_tlast;
    logic                cfg_we    = 1'b0;
    logic [SIZE_W-1:0]   cfg_wdata = '0;

    mm_row_scoreboard sb = new();
    bit a_loaded[DEF_MAX_N * DEF_MAX_N];
    bit b_loaded[DEF_MAX_N * DEF_MAX_N];
    int send_gap_pct = 0;
    int sink_gap_pct = 0;
    bit hold_sink    = 0;
    int stall_cycles = 0;

    matrix_multiply_fixed_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // output side: random stalls, one long hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                hold_sink = 0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(1, 100) <= sink_gap_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[3:0], m_tdata[51:4], m_tlast);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic sender_pause(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_beat(input logic [1:0] op, input logic [3:0] row,
                             input logic [3:0] col, input logic [15:0] val);
        if ($urandom_range(1, 100) <= send_gap_pct)
            sender_pause($urandom_range(1, 15));
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, col, row};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_beat(op, row, col, val);
    endtask

    task automatic load_elem(input logic [1:0] op, input logic [3:0] row,
                             input logic [3:0] col, input logic [15:0] val);
        send_beat(op, row, col, val);
        if (op == OP_WRITE_A)
            a_loaded[{row, col}] = 1;
        else
            b_loaded[{row, col}] = 1;
    endtask

    // fills every entry the row will read before asking for it
    task automatic request_row(input logic [3:0] r);
        int n;
        int j;
        int k;
        n = sb.order();
        if (r < n)
        begin
            for (k = 0; k < n; k++)
                if (!a_loaded[{r, 4'(k)}])
                    load_elem(OP_WRITE_A, r, 4'(k), rand_elem());
            for (k = 0; k < n; k++)
                for (j = 0; j < n; j++)
                    if (!b_loaded[{4'(k), 4'(j)}])
                        load_elem(OP_WRITE_B, 4'(k), 4'(j), rand_elem());
        end
        send_beat(OP_ROW, r, 4'($urandom), 16'($urandom));
    endtask

    task automatic settle();
        sender_pause(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_order(input logic [SIZE_W-1:0] v);
        settle();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_size(v);
    endtask

    task automatic random_phase(input logic [SIZE_W-1:0] size, input int count,
                                input int gap_pct, input bit long_hold);
        int         n;
        int         i;
        int         pick;
        logic [3:0] r;
        set_order(size);
        send_gap_pct = gap_pct;
        sink_gap_pct = gap_pct;
        n = sb.order();
        if (long_hold)
        begin
            hold_sink = 1;
            request_row(4'd0);
        end
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 6)
                request_row(4'($urandom_range(0, n - 1)));
            else if (pick < 17)
            begin
                r = (pick < 12) ? 4'($urandom_range(0, n - 1)) : 4'($urandom);
                load_elem($urandom_range(0, 1) ? OP_WRITE_B : OP_WRITE_A, r,
                          $urandom_range(0, 1) ? 4'($urandom_range(0, n - 1)) : 4'($urandom),
                          rand_elem());
            end
            else if (pick < 19)
                request_row(4'($urandom));
            else
                send_beat(OP_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // order after reset is the full size
        send_gap_pct = 10;
        sink_gap_pct = 10;
        request_row(4'd0);

        // extremes at order 2
        set_order(5'd2);
        load_elem(OP_WRITE_A, 4'd0, 4'd0, 16'h8000);
        load_elem(OP_WRITE_A, 4'd0, 4'd1, 16'h8000);
        load_elem(OP_WRITE_B, 4'd0, 4'd0, 16'h8000);
        load_elem(OP_WRITE_B, 4'd1, 4'd0, 16'h8000);
        load_elem(OP_WRITE_B, 4'd0, 4'd1, 16'h7fff);
        load_elem(OP_WRITE_B, 4'd1, 4'd1, 16'hffff);
        load_elem(OP_WRITE_A, 4'd1, 4'd0, 16'h7fff);
        load_elem(OP_WRITE_A, 4'd1, 4'd1, 16'h0000);
        request_row(4'd0);
        request_row(4'd1);
        request_row(4'd2);
        request_row(4'd15);
        send_beat(OP_UNUSED, 4'hf, 4'hf, 16'hffff);
        load_elem(OP_WRITE_B, 4'hf, 4'hf, 16'h7fff);
        load_elem(OP_WRITE_A, 4'd0, 4'd1, 16'h0001);
        send_beat(OP_ROW, 4'd0, 4'hf, 16'hffff);
        request_row(4'd1);

        random_phase(5'd1, 6, 20, 0);
        random_phase(5'd0, 6, 0, 0);
        random_phase(5'd4, 12, 15, 1);

        // size above the store acts as the full size
        set_order(5'd31);
        request_row(4'd0);
        set_order(5'd16);
        request_row(4'd0);

        random_phase(5'd3, 10, 30, 0);
        random_phase(5'd5, 12, 0, 0);

        settle();
        if (!sb.failed && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
